// File: sv/bmhq_pkg.sv
// Package for the binary min-heap queue: transaction structs, heap entry type,
// controller states, command and status structs, and code constants.
// Depends on nothing; every other file of the block imports it.
package bmhq_pkg;

	localparam int KEY_W = 32;
	localparam int PAY_W = 32;
	localparam int OCC_W = 11;
	localparam int STS_W = 2;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP = 1'b1;

	localparam logic [STS_W-1:0] ST_OK = 2'd0;
	localparam logic [STS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic kind;
		logic [KEY_W-1:0] key_in;
		logic [PAY_W-1:0] payload_in;
	} in_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_out;
		logic [PAY_W-1:0] payload_out;
		logic popped;
		logic [STS_W-1:0] status;
		logic [OCC_W-1:0] occupancy;
	} out_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_POP_ROOT,
		S_POP_LAST,
		S_DN,
		S_DN_CMP,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic start_push;
		logic start_pop;
		logic set_full;
		logic set_empty;
		logic cap_root;
		logic cap_last;
		logic up_read;
		logic up_move;
		logic dn_read;
		logic dn_move;
		logic put_x;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic pos_zero;
		logic lc_in;
		logic up_stop;
		logic dn_pick;
		logic out_busy;
	} sts_t;

endpackage

// File: sv/bmhq_ctrl.sv
// Controller state machine of the binary min-heap queue.
// Sequences push sift-up and pop sift-down steps; depends on bmhq_pkg.
module bmhq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_kind,
	input logic out_ready,
	input bmhq_pkg::sts_t sts,
	output bmhq_pkg::cmd_t cmd
);
	import bmhq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == KIND_PUSH) begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
							state_d = S_RESULT;
						end else begin
							cmd.start_push = 1'b1;
							state_d = S_UP;
						end
					end else begin
						if (sts.empty) begin
							cmd.set_empty = 1'b1;
							state_d = S_RESULT;
						end else begin
							cmd.start_pop = 1'b1;
							state_d = S_POP_ROOT;
						end
					end
				end
			end
			S_UP: begin
				if (sts.pos_zero) begin
					cmd.put_x = 1'b1;
					state_d = S_RESULT;
				end else begin
					cmd.up_read = 1'b1;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_stop) begin
					cmd.put_x = 1'b1;
					state_d = S_RESULT;
				end else begin
					cmd.up_move = 1'b1;
					state_d = S_UP;
				end
			end
			S_POP_ROOT: begin
				cmd.cap_root = 1'b1;
				state_d = S_POP_LAST;
			end
			S_POP_LAST: begin
				cmd.cap_last = 1'b1;
				state_d = S_DN;
			end
			S_DN: begin
				if (!sts.lc_in) begin
					cmd.put_x = 1'b1;
					state_d = S_RESULT;
				end else begin
					cmd.dn_read = 1'b1;
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (sts.dn_pick) begin
					cmd.dn_move = 1'b1;
					state_d = S_DN;
				end else begin
					cmd.put_x = 1'b1;
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!sts.out_busy || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: sv/bmhq_dp.sv
// Datapath of the binary min-heap queue: heap memory, moving entry, position,
// entry count, result assembly and output register. Depends on bmhq_pkg.
module bmhq_dp #(
	parameter int CAPACITY = 1024
) (
	input logic clk,
	input logic arst_n,
	input bmhq_pkg::in_t in_item,
	input bmhq_pkg::cmd_t cmd,
	output bmhq_pkg::sts_t sts,
	input logic out_ready,
	output logic out_valid,
	output bmhq_pkg::out_t out_item
);
	import bmhq_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = ADDR_W + 2;

	entry_t mem [CAPACITY];
	entry_t rd_a_q;
	entry_t rd_b_q;
	entry_t x_q;
	logic [ADDR_W-1:0] pos_q;
	logic [CNT_W-1:0] count_q;

	logic [KEY_W-1:0] res_key_q;
	logic [PAY_W-1:0] res_pay_q;
	logic res_popped_q;
	logic [STS_W-1:0] res_status_q;
	out_t out_q;
	logic out_valid_q;

	logic [IDX_W-1:0] lc;
	logic [IDX_W-1:0] rc;
	logic [IDX_W-1:0] count_ext;
	logic [ADDR_W-1:0] pos_m1;
	logic [ADDR_W-1:0] parent;
	logic lc_in;
	logic rc_in;
	logic pick_l;
	logic pick_r;
	logic [KEY_W-1:0] best_key;
	entry_t child;
	logic [ADDR_W-1:0] child_idx;
	logic rd_a_en;
	logic rd_b_en;
	logic [ADDR_W-1:0] rd_a_addr;
	logic wr_en;
	entry_t wr_data;
	logic [CNT_W+OCC_W-1:0] occ_ext;

	assign lc = {1'b0, pos_q, 1'b1};
	assign rc = lc + IDX_W'(1);
	assign count_ext = {{(IDX_W - CNT_W){1'b0}}, count_q};
	assign pos_m1 = pos_q - ADDR_W'(1);
	assign parent = pos_m1 >> 1;
	assign lc_in = lc < count_ext;
	assign rc_in = rc < count_ext;

	assign pick_l = lc_in && (rd_a_q.key < x_q.key);
	assign best_key = pick_l ? rd_a_q.key : x_q.key;
	assign pick_r = rc_in && (rd_b_q.key < best_key);
	assign child = pick_r ? rd_b_q : rd_a_q;
	assign child_idx = pick_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

	assign sts.full = count_q == CNT_W'(CAPACITY);
	assign sts.empty = count_q == '0;
	assign sts.pos_zero = pos_q == '0;
	assign sts.lc_in = lc_in;
	assign sts.up_stop = rd_a_q.key <= x_q.key;
	assign sts.dn_pick = pick_l | pick_r;
	assign sts.out_busy = out_valid_q;

	always_comb begin
		rd_a_addr = '0;
		if (cmd.cap_root) begin
			rd_a_addr = count_q[ADDR_W-1:0];
		end else if (cmd.up_read) begin
			rd_a_addr = parent;
		end else if (cmd.dn_read) begin
			rd_a_addr = lc[ADDR_W-1:0];
		end
	end

	assign rd_a_en = cmd.start_pop | cmd.cap_root | cmd.up_read | cmd.dn_read;
	assign rd_b_en = cmd.dn_read;
	assign wr_en = cmd.put_x | cmd.up_move | cmd.dn_move;

	always_comb begin
		wr_data = x_q;
		if (cmd.up_move) begin
			wr_data = rd_a_q;
		end else if (cmd.dn_move) begin
			wr_data = child;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wr_data;
		end
		if (rd_a_en) begin
			rd_a_q <= mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_q <= mem[rc[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.start_push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.start_pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_push) begin
			pos_q <= count_q[ADDR_W-1:0];
			x_q <= '{key: in_item.key_in, payload: in_item.payload_in};
		end else if (cmd.cap_last) begin
			pos_q <= '0;
			x_q <= rd_a_q;
		end else if (cmd.up_move) begin
			pos_q <= parent;
		end else if (cmd.dn_move) begin
			pos_q <= child_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_push || cmd.start_pop || cmd.set_full || cmd.set_empty) begin
			res_key_q <= '0;
			res_pay_q <= '0;
			res_popped_q <= 1'b0;
			res_status_q <= cmd.set_full ? ST_FULL : (cmd.set_empty ? ST_EMPTY : ST_OK);
		end else if (cmd.cap_root) begin
			res_key_q <= rd_a_q.key;
			res_pay_q <= rd_a_q.payload;
			res_popped_q <= 1'b1;
		end
	end

	assign occ_ext = {{OCC_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.key_out <= res_key_q;
			out_q.payload_out <= res_pay_q;
			out_q.popped <= res_popped_q;
			out_q.status <= res_status_q;
			out_q.occupancy <= occ_ext[OCC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("Entry count exceeds capacity.");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.put_x, cmd.up_move, cmd.dn_move}))
		else $error("More than one heap write source is active.");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_push |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("Push did not advance the entry count.");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("Output register overwritten before its transaction.");

	a_popped_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.popped) |-> out_q.status == ST_OK)
		else $error("Popped result carries an error status.");

endmodule

// File: sv/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue: one push or pop transaction at a time over a
// heap memory with one write and two registered read ports. A push is accepted
// in the idle state and then repeats a parent read step and a compare-and-write
// step per level until the new entry reaches the root or stops below a parent
// whose key is not larger. A pop captures the root, then the last entry, and then
// repeats a child read step and a compare-and-write step per level until the
// moved entry reaches a leaf or stops above its children. A refused push or pop
// goes straight to the result state. The result waits in an output register, and
// a new result cannot be loaded until the previous one is taken; the next
// transaction is accepted once the result has moved there. The heap memory holds
// no reset value and needs no clearing pass.
module binary_min_heap_queue_unit #(
	parameter int CAPACITY = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input bmhq_pkg::in_t in_item,
	output logic out_valid,
	input logic out_ready,
	output bmhq_pkg::out_t out_item
);
	import bmhq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bmhq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_kind(in_item.kind),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	bmhq_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.cmd(cmd),
		.sts(sts),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_item(out_item)
	);

endmodule
